// ----- hw/rtl/ilt_pkg.sv -----
// ----------------------------------------------------------------------------
// ilt_pkg
// Shared types and constants of the inactivity lock timer.
// ----------------------------------------------------------------------------
package ilt_pkg;

  localparam int unsigned FieldTimeW = 32;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [15:0] TimeoutReset   = 16'd600;
  localparam logic [15:0] JumpLimitReset = 16'd120;
  localparam logic        HonourReset    = 1'b1;
  localparam logic [15:0] PostponeSecs   = 16'd60;

  typedef enum logic [2:0] {
    REQ_TICK        = 3'd0,
    REQ_ACTIVITY    = 3'd1,
    REQ_SET_TRIGGER = 3'd2,
    REQ_POSTPONE    = 3'd3,
    REQ_START       = 3'd4,
    REQ_STOP        = 3'd5
  } req_kind_e;

  typedef enum logic [1:0] {
    CFG_TIMEOUT    = 2'd0,
    CFG_JUMP_LIMIT = 2'd1,
    CFG_DPMS_HONOR = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]            req_type;
    logic [FieldTimeW-1:0] now_seconds;
    logic [FieldTimeW-1:0] new_trigger;
    logic [1:0]            dpms_mode;
    logic                  dpms_enabled;
    logic                  saver_disabled;
  } req_item_t;

  typedef struct packed {
    logic                  lock_request;
    logic [FieldTimeW-1:0] trigger_time;
  } rsp_item_t;

  typedef struct packed {
    logic [15:0] timeout_seconds;
    logic [15:0] jump_limit_seconds;
    logic        dpms_honour;
  } cfg_t;

endpackage

// ----- hw/rtl/ilt_if.sv -----
// ----------------------------------------------------------------------------
// ilt_if
// Handshake channels of the inactivity lock timer.
// ----------------------------------------------------------------------------
interface ilt_req_if;
  import ilt_pkg::*;
  logic      valid;
  logic      ready;
  req_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ilt_rsp_if;
  import ilt_pkg::*;
  logic      valid;
  logic      ready;
  rsp_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ilt_cfg_if;
  import ilt_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/ilt_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// ilt_cfg_regs
// Configuration register file: timeout, jump limit, display power honor.
// ----------------------------------------------------------------------------
module ilt_cfg_regs import ilt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ilt_cfg_if.sink    cfg_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_TIMEOUT:    cfg_d.timeout_seconds    = cfg_i.data;
        CFG_JUMP_LIMIT: cfg_d.jump_limit_seconds = cfg_i.data;
        CFG_DPMS_HONOR: cfg_d.dpms_honour        = cfg_i.data[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_seconds    <= TimeoutReset;
      cfg_q.jump_limit_seconds <= JumpLimitReset;
      cfg_q.dpms_honour        <= HonourReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/ilt_next.sv -----
// ----------------------------------------------------------------------------
// ilt_next
// Next-state logic: trigger update, jump test, activation and lock decision.
// ----------------------------------------------------------------------------
module ilt_next import ilt_pkg::*; #(
  parameter int unsigned TimeW = 32
) (
  input  req_item_t        req_i,
  input  cfg_t             cfg_i,
  input  logic [TimeW-1:0] trig_i,
  input  logic [TimeW-1:0] last_i,
  input  logic             armed_i,
  output logic [TimeW-1:0] trig_o,
  output logic [TimeW-1:0] last_o,
  output logic             armed_o,
  output logic             lock_o
);

  logic [TimeW-1:0] now_w;
  logic [TimeW-1:0] cand_w;
  logic [TimeW:0]   sum_to;
  logic [TimeW:0]   sum_pp;
  logic [TimeW-1:0] reset_val;
  logic [TimeW-1:0] postpone_val;
  logic             jump_fwd;
  logic             jump_back;
  logic [TimeW-1:0] trig_t;
  logic             act;

  assign now_w  = TimeW'(req_i.now_seconds);
  assign cand_w = TimeW'(req_i.new_trigger);

  assign sum_to       = {1'b0, now_w} + (TimeW+1)'(cfg_i.timeout_seconds);
  assign sum_pp       = {1'b0, now_w} + (TimeW+1)'(PostponeSecs);
  assign reset_val    = sum_to[TimeW] ? '1 : sum_to[TimeW-1:0];
  assign postpone_val = sum_pp[TimeW] ? '1 : sum_pp[TimeW-1:0];

  assign jump_fwd  = (now_w > last_i) &&
                     ((now_w - last_i) > TimeW'(cfg_i.jump_limit_seconds));
  assign jump_back = (last_i > now_w) &&
                     ({1'b0, last_i - now_w} >
                      (TimeW+1)'(cfg_i.jump_limit_seconds) + (TimeW+1)'(1));

  always_comb begin
    trig_o  = trig_i;
    last_o  = last_i;
    armed_o = armed_i;
    lock_o  = 1'b0;
    trig_t  = trig_i;
    act     = 1'b0;
    case (req_kind_e'(req_i.req_type))
      REQ_TICK: begin
        if (jump_fwd || jump_back) trig_t = reset_val;
        last_o = now_w;
        if (now_w >= trig_t) begin
          trig_t = reset_val;
          act    = 1'b1;
        end
        if (req_i.dpms_mode != 2'd0) act = 1'b1;
        if (!req_i.dpms_enabled && cfg_i.dpms_honour) begin
          act    = 1'b0;
          trig_t = reset_val;
        end
        if (req_i.saver_disabled) act = 1'b0;
        trig_o = trig_t;
        lock_o = armed_i && act;
      end
      REQ_ACTIVITY:    trig_o = reset_val;
      REQ_SET_TRIGGER: if (cand_w < trig_i) trig_o = cand_w;
      REQ_POSTPONE:    trig_o = postpone_val;
      REQ_START: begin
        trig_o  = reset_val;
        last_o  = now_w;
        armed_o = 1'b1;
      end
      REQ_STOP:        armed_o = 1'b0;
      default:         trig_o = trig_i;
    endcase
  end

endmodule

// ----- hw/rtl/idle_lock_timer.sv -----
// ----------------------------------------------------------------------------
// idle_lock_timer
// Inactivity lock timer: input register, next-state logic, result register.
// Path: an accepted request is held in the input register, then its result is registered in the result register.
// Throughput: one request per cycle while responses are taken; the state update is a single pass.
// Reset: async active low; state clears, configuration takes its defaults.
// ----------------------------------------------------------------------------
module idle_lock_timer import ilt_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ilt_cfg_if.sink   cfg_i,
  ilt_req_if.sink   req_i,
  ilt_rsp_if.source rsp_o
);

  cfg_t                  cfg;
  logic                  in_vld_q;
  req_item_t             in_q;
  logic                  out_vld_q;
  rsp_item_t             out_q;
  logic [TIME_WIDTH-1:0] trig_q, trig_d;
  logic [TIME_WIDTH-1:0] last_q, last_d;
  logic                  armed_q, armed_d;
  logic                  lock_d;
  logic                  adv;

  ilt_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  ilt_next #(.TimeW(TIME_WIDTH)) u_next (
    .req_i   (in_q),
    .cfg_i   (cfg),
    .trig_i  (trig_q),
    .last_i  (last_q),
    .armed_i (armed_q),
    .trig_o  (trig_d),
    .last_o  (last_d),
    .armed_o (armed_d),
    .lock_o  (lock_d)
  );

  assign adv         = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      trig_q    <= '0;
      last_q    <= '0;
      armed_q   <= 1'b0;
    end else begin
      if (req_i.ready) in_vld_q <= req_i.valid;
      if (adv) begin
        out_vld_q <= 1'b1;
        trig_q    <= trig_d;
        last_q    <= last_d;
        armed_q   <= armed_d;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) in_q <= req_i.data;
    if (adv) begin
      out_q.lock_request <= lock_d;
      out_q.trigger_time <= FieldTimeW'(trig_d);
    end
  end

  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = out_q;

`ifndef NO_ASSERTIONS
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !out_vld_q |-> adv)
    else $error("held request not advanced into empty response stage");

  a_lock_needs_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(adv) && out_q.lock_request |-> armed_q)
    else $error("lock raised while disarmed");

  a_lock_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(adv) && ($past(in_q.req_type) != REQ_TICK) |-> !out_q.lock_request)
    else $error("lock raised by a non-tick request");
`endif

endmodule

// ----- test/idle_lock_timer_tb.sv -----
// ----------------------------------------------------------------------------
// idle_lock_timer_tb
// Self-checking bench for the inactivity lock timer. A scoreboard mirrors
// the trigger, last tick time and arm state from each accepted request and
// checks every response field in order. Directed requests cover clock
// jumps at the limit, saturation and the display power and screensaver
// overrides. Random phases then sweep the settings under varied
// back-pressure, including one long response hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import ilt_pkg::*;

class lock_scoreboard;
  logic [15:0] timeout_s;
  logic [15:0] jump_s;
  logic        honour;
  logic [31:0] trigger_at;
  logic [31:0] last_tick;
  logic        armed;
  rsp_item_t   expected_q[$];
  int          errors;
  int          checked;
  int          locks;

  function new();
    timeout_s  = TimeoutReset;
    jump_s     = JumpLimitReset;
    honour     = HonourReset;
    trigger_at = '0;
    last_tick  = '0;
    armed      = 1'b0;
    errors     = 0;
    checked    = 0;
    locks      = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void write_register(logic [1:0] idx, logic [15:0] val);
    case (idx)
      CFG_TIMEOUT: timeout_s = val;
      CFG_JUMP_LIMIT: jump_s = val;
      CFG_DPMS_HONOR: honour = val[0];
      default: ;
    endcase
  endfunction

  function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? '1 : s[31:0];
  endfunction

  task report_mismatch(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task note_request(req_item_t r);
    rsp_item_t   want;
    logic        fire;
    logic [31:0] now;
    now  = r.now_seconds;
    fire = 1'b0;
    want.lock_request = 1'b0;
    case (r.req_type)
      REQ_TICK: begin
        if ((now > last_tick && now - last_tick > {16'd0, jump_s}) ||
            (last_tick > now && 33'(last_tick - now) > 33'(jump_s) + 33'd1))
          trigger_at = sat_add(now, {16'd0, timeout_s});
        last_tick = now;
        if (now >= trigger_at) begin
          trigger_at = sat_add(now, {16'd0, timeout_s});
          fire = 1'b1;
        end
        if (r.dpms_mode != 2'd0) fire = 1'b1;
        if (!r.dpms_enabled && honour) begin
          fire = 1'b0;
          trigger_at = sat_add(now, {16'd0, timeout_s});
        end
        if (r.saver_disabled) fire = 1'b0;
        want.lock_request = armed && fire;
      end
      REQ_ACTIVITY: trigger_at = sat_add(now, {16'd0, timeout_s});
      REQ_SET_TRIGGER: begin
        if (r.new_trigger < trigger_at) trigger_at = r.new_trigger;
      end
      REQ_POSTPONE: trigger_at = sat_add(now, {16'd0, PostponeSecs});
      REQ_START: begin
        trigger_at = sat_add(now, {16'd0, timeout_s});
        last_tick  = now;
        armed      = 1'b1;
      end
      REQ_STOP: armed = 1'b0;
      default: ;
    endcase
    want.trigger_time = trigger_at;
    if (want.lock_request) locks++;
    expected_q.push_back(want);
  endtask

  task check_response(rsp_item_t got);
    rsp_item_t want;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("unexpected response lock %0b trigger %0d",
                                got.lock_request, got.trigger_time));
      return;
    end
    want = expected_q.pop_front();
    checked++;
    if (got.lock_request !== want.lock_request)
      report_mismatch($sformatf("response %0d lock_request %0b, want %0b",
                                checked, got.lock_request, want.lock_request));
    if (got.trigger_time !== want.trigger_time)
      report_mismatch($sformatf("response %0d trigger_time %0d, want %0d",
                                checked, got.trigger_time, want.trigger_time));
  endtask
endclass

module idle_lock_timer_tb;
  localparam int          CycleLimit    = 500000;
  localparam int          PhaseRequests = 250;
  localparam logic [2:0]  ReqUnused6    = 3'd6;
  localparam logic [2:0]  ReqUnused7    = 3'd7;
  localparam logic [31:0] TimeMax       = 32'hFFFF_FFFF;

  logic clk = 1'b0;
  logic rst_n;
  logic hold_rsp;
  int   cycles = 0;
  int   send_idle_pct;
  int   rsp_stall_pct;
  int   requests;
  int   unsigned cur_timeout;
  int   unsigned cur_jump;
  logic [31:0] wall;

  int unsigned timeout_tab[8] = '{5, 0, 65535, 40, 1, 65535, 600, 200};
  int unsigned jump_tab[8]    = '{3, 0, 65535, 20, 65535, 0, 120, 1};
  bit          honour_tab[8]  = '{1, 0, 1, 0, 1, 0, 1, 0};

  lock_scoreboard sb;

  ilt_cfg_if cfg_if ();
  ilt_req_if req_if ();
  ilt_rsp_if rsp_if ();

  idle_lock_timer #(.TIME_WIDTH(32)) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_if),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_if.ready <= !hold_rsp && ($urandom_range(99) >= rsp_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) sb.write_register(cfg_if.index, cfg_if.data);
      if (req_if.valid && req_if.ready) sb.note_request(req_if.data);
      if (rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.data);
    end
  end

  function automatic req_item_t make_req(logic [2:0] kind, logic [31:0] now,
                                         logic [31:0] cand = '0, logic [1:0] mode = 2'd0,
                                         logic en = 1'b1, logic saver = 1'b0);
    req_item_t r;
    r.req_type       = kind;
    r.now_seconds    = now;
    r.new_trigger    = cand;
    r.dpms_mode      = mode;
    r.dpms_enabled   = en;
    r.saver_disabled = saver;
    return r;
  endfunction

  function automatic req_item_t random_request();
    req_item_t r;
    int        pick;
    pick = $urandom_range(99);
    if (pick < 52)      r.req_type = REQ_TICK;
    else if (pick < 64) r.req_type = REQ_ACTIVITY;
    else if (pick < 72) r.req_type = REQ_SET_TRIGGER;
    else if (pick < 78) r.req_type = REQ_POSTPONE;
    else if (pick < 87) r.req_type = REQ_START;
    else if (pick < 94) r.req_type = REQ_STOP;
    else if (pick < 97) r.req_type = ReqUnused6;
    else                r.req_type = ReqUnused7;
    pick = $urandom_range(99);
    if (pick < 70)      wall = wall + $urandom_range(0, cur_timeout / 6 + 3);
    else if (pick < 80) wall = wall + cur_jump + $urandom_range(0, 3) - 1;
    else if (pick < 88) wall = wall - cur_jump - $urandom_range(0, 3);
    else if (pick < 94) wall = $urandom();
    else                wall = TimeMax - $urandom_range(0, 200);
    r.now_seconds = wall;
    r.new_trigger = ($urandom_range(99) < 70) ? wall + $urandom_range(0, cur_timeout + 10)
                                              : $urandom();
    r.dpms_mode      = ($urandom_range(99) < 80) ? 2'd0 : 2'($urandom_range(1, 3));
    r.dpms_enabled   = $urandom_range(99) >= 15;
    r.saver_disabled = $urandom_range(99) < 12;
    return r;
  endfunction

  task automatic send_request(req_item_t r);
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    requests++;
    if ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  initial begin
    sb           = new();
    rst_n        = 1'b0;
    hold_rsp     = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data  = '0;
    rsp_if.ready = 1'b0;
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    requests     = 0;
    wall         = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(make_req(REQ_TICK, 32'd0));
    send_request(make_req(REQ_START, 32'd1000));
    send_request(make_req(REQ_TICK, 32'd1100));
    send_request(make_req(REQ_TICK, 32'd1220));
    send_request(make_req(REQ_TICK, 32'd1341));
    send_request(make_req(REQ_ACTIVITY, 32'd1400));
    send_request(make_req(REQ_SET_TRIGGER, 32'd1400, 32'd1500));
    send_request(make_req(REQ_SET_TRIGGER, 32'd1400, 32'd1800));
    send_request(make_req(REQ_TICK, 32'd1460));
    send_request(make_req(REQ_TICK, 32'd1500));
    send_request(make_req(REQ_TICK, 32'd1379));
    send_request(make_req(REQ_TICK, 32'd1257));
    send_request(make_req(REQ_TICK, 32'd1260, '0, 2'd1));
    send_request(make_req(REQ_TICK, 32'd1262, '0, 2'd3, 1'b0));
    send_request(make_req(REQ_TICK, 32'd1264, '0, 2'd2, 1'b1, 1'b1));
    send_request(make_req(REQ_POSTPONE, 32'hFFFF_FFF0));
    send_request(make_req(REQ_ACTIVITY, TimeMax));
    send_request(make_req(REQ_TICK, TimeMax));
    send_request(make_req(REQ_TICK, 32'd0));
    send_request(make_req(REQ_STOP, 32'd5));
    send_request(make_req(REQ_TICK, 32'd6, '0, 2'd3));
    send_request(make_req(ReqUnused6, TimeMax, TimeMax, 2'd3, 1'b0, 1'b1));
    send_request(make_req(ReqUnused7, 32'h5A5A_A5A5, 32'hA5A5_5A5A, 2'd1, 1'b1, 1'b0));
    send_request(make_req(REQ_SET_TRIGGER, 32'd7, 32'd0));
    send_request(make_req(REQ_START, TimeMax, TimeMax, 2'd3, 1'b0, 1'b1));
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      cur_timeout = timeout_tab[phase];
      cur_jump    = jump_tab[phase];
      write_reg(CFG_TIMEOUT, 16'(cur_timeout));
      write_reg(CFG_JUMP_LIMIT, 16'(cur_jump));
      write_reg(CFG_DPMS_HONOR, 16'(honour_tab[phase]));
      cfg_if.valid <= 1'b0;
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          rsp_stall_pct <= 0;
        end
        1: begin
          send_idle_pct = 67;
          rsp_stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          rsp_stall_pct <= 67;
        end
        default: begin
          send_idle_pct = 20;
          rsp_stall_pct <= 20;
        end
      endcase
      if (phase == 4) begin
        fork
          begin
            hold_rsp <= 1'b1;
            repeat (400) @(posedge clk);
            hold_rsp <= 1'b0;
          end
        join_none
      end
      wall = $urandom();
      send_request(make_req(REQ_START, wall));
      for (int n = 0; n < PhaseRequests; n++) send_request(random_request());
      drain();
    end

    repeat (10) @(posedge clk);
    $display("covered %0d requests over 8 settings, %0d responses checked, %0d lock requests",
             requests, sb.checked, sb.locks);
    $display("mismatches found: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
hw/rtl/ilt_pkg.sv
hw/rtl/ilt_if.sv
hw/rtl/ilt_cfg_regs.sv
hw/rtl/ilt_next.sv
hw/rtl/idle_lock_timer.sv
test/idle_lock_timer_tb.sv
